[rtl/priority_round_robin_scheduler_macros.svh]
// Assertion macros used by the checker file of the scheduler.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prrs check failed");

// The consequent must hold starting in the cycle after the antecedent.
`define PRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prrs check failed");

`endif

[rtl/prrs_pkg.sv]
package prrs_pkg;

    // Queue geometry.
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int TREE_N  = 1 << SLOT_W;

    // Field widths.
    localparam int PRI_W   = 4;
    localparam int BURST_W = 16;
    localparam int ID_W    = 16;
    localparam int STAT_W  = 2;

    // Stream packing.
    localparam int IN_TDATA_W  = 24;
    localparam int IN_PAD_W    = IN_TDATA_W - PRI_W - BURST_W;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ID_W - BURST_W - 1;

    // Reset values.
    localparam logic [BURST_W-1:0] QUANTUM_RST = BURST_W'(10);
    localparam logic [ID_W-1:0]    ID_RST      = ID_W'(1);

    typedef enum logic {
        OP_ADD      = 1'b0,
        OP_DISPATCH = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

[rtl/prrs_ctrl.sv]
module prrs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output prrs_pkg::cmd_t     cmd
);

    prrs_pkg::state_t state_reg;
    prrs_pkg::state_t state_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_vld_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prrs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = prrs_pkg::ST_EXEC;
                end
            end
            prrs_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = prrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = prrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands, handshake and output valid.
    always_comb begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        unique case (state_reg)
            prrs_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            prrs_pkg::ST_EXEC: begin
                cmd.execute = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        if (cmd.execute) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= prrs_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;

endmodule

[rtl/prrs_dp.sv]
module prrs_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  prrs_pkg::cmd_t                     cmd,
    input  logic                               in_opcode,
    input  logic [prrs_pkg::PRI_W-1:0]         in_priority_req,
    input  logic [prrs_pkg::BURST_W-1:0]       in_burst,
    input  logic                               cfg_wr_en,
    input  logic [prrs_pkg::BURST_W-1:0]       cfg_wr_data,
    output prrs_pkg::status_t                  out_status,
    output logic [prrs_pkg::ID_W-1:0]          out_task_id,
    output logic [prrs_pkg::BURST_W-1:0]       out_slice,
    output logic                               out_finished
);

    localparam int NODES = 2 * prrs_pkg::TREE_N;

    // Captured item.
    prrs_pkg::op_t                   op_reg;
    logic [prrs_pkg::PRI_W-1:0]      pri_reg;
    logic [prrs_pkg::BURST_W-1:0]    burst_reg;

    // Queue state; slot 0 is the head and the first cnt_reg slots are live.
    logic [prrs_pkg::ID_W-1:0]       slot_id_reg  [prrs_pkg::SLOTS];
    logic [prrs_pkg::PRI_W-1:0]      slot_pri_reg [prrs_pkg::SLOTS];
    logic [prrs_pkg::BURST_W-1:0]    slot_rem_reg [prrs_pkg::SLOTS];
    logic [prrs_pkg::CNT_W-1:0]      cnt_reg;
    logic [prrs_pkg::ID_W-1:0]       next_id_reg;
    logic [prrs_pkg::BURST_W-1:0]    quantum_reg;
    logic [prrs_pkg::SLOT_W-1:0]     pick_reg;

    // Result register.
    prrs_pkg::status_t               status_reg;
    logic [prrs_pkg::ID_W-1:0]       id_reg;
    logic [prrs_pkg::BURST_W-1:0]    slice_reg;
    logic                            fin_reg;

    // Selection tree.
    logic                            node_vld [NODES];
    logic [prrs_pkg::PRI_W-1:0]      node_pri [NODES];
    logic [prrs_pkg::SLOT_W-1:0]     node_idx [NODES];

    // Dispatch arithmetic.
    logic [prrs_pkg::SLOT_W-1:0]     last_slot;
    logic [prrs_pkg::SLOT_W-1:0]     tail_slot;
    logic [prrs_pkg::BURST_W-1:0]    sel_rem;
    logic [prrs_pkg::BURST_W-1:0]    slice_val;
    logic [prrs_pkg::BURST_W-1:0]    rem_left;
    logic                            q_full;
    logic                            q_empty;

    // Highest priority, earliest in queue order; the right child wins only
    // on a strictly higher priority.
    always_comb begin
        for (int i = 0; i < prrs_pkg::TREE_N; i++) begin
            node_idx[prrs_pkg::TREE_N + i] = prrs_pkg::SLOT_W'(i);
            if (i < prrs_pkg::SLOTS) begin
                node_vld[prrs_pkg::TREE_N + i] = prrs_pkg::CNT_W'(i) < cnt_reg;
                node_pri[prrs_pkg::TREE_N + i] = slot_pri_reg[i];
            end else begin
                node_vld[prrs_pkg::TREE_N + i] = 1'b0;
                node_pri[prrs_pkg::TREE_N + i] = '0;
            end
        end
        node_vld[0] = 1'b0;
        node_pri[0] = '0;
        node_idx[0] = '0;
        for (int k = prrs_pkg::TREE_N - 1; k >= 1; k--) begin
            if (node_vld[2*k+1] && (!node_vld[2*k] || node_pri[2*k+1] > node_pri[2*k])) begin
                node_vld[k] = 1'b1;
                node_pri[k] = node_pri[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end else begin
                node_vld[k] = node_vld[2*k];
                node_pri[k] = node_pri[2*k];
                node_idx[k] = node_idx[2*k];
            end
        end
    end

    // The winner is registered every cycle; the queue is stable while idle.
    always_ff @(posedge aclk) begin
        pick_reg <= node_idx[1];
    end

    assign q_full    = cnt_reg == prrs_pkg::CNT_W'(prrs_pkg::SLOTS);
    assign q_empty   = cnt_reg == '0;
    assign tail_slot = cnt_reg[prrs_pkg::SLOT_W-1:0];
    assign last_slot = prrs_pkg::SLOT_W'(cnt_reg - prrs_pkg::CNT_W'(1));
    assign sel_rem   = slot_rem_reg[pick_reg];
    assign slice_val = (sel_rem < quantum_reg) ? sel_rem : quantum_reg;
    assign rem_left  = sel_rem - slice_val;

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= prrs_pkg::op_t'(in_opcode);
            pri_reg   <= in_priority_req;
            burst_reg <= in_burst;
        end
    end

    // Quantum register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= prrs_pkg::QUANTUM_RST;
        end else if (cfg_wr_en) begin
            quantum_reg <= cfg_wr_data;
        end
    end

    // Fill count and identifier counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            next_id_reg <= prrs_pkg::ID_RST;
        end else if (cmd.execute) begin
            if (op_reg == prrs_pkg::OP_ADD) begin
                if (!q_full) begin
                    cnt_reg     <= cnt_reg + prrs_pkg::CNT_W'(1);
                    next_id_reg <= next_id_reg + prrs_pkg::ID_W'(1);
                end
            end else if (!q_empty && rem_left == '0) begin
                cnt_reg <= cnt_reg - prrs_pkg::CNT_W'(1);
            end
        end
    end

    // Slot storage: append at the tail, or rotate the picked task to the tail.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            if (op_reg == prrs_pkg::OP_ADD) begin
                if (!q_full) begin
                    slot_id_reg[tail_slot]  <= next_id_reg;
                    slot_pri_reg[tail_slot] <= pri_reg;
                    slot_rem_reg[tail_slot] <= burst_reg;
                end
            end else if (!q_empty) begin
                for (int i = 0; i < prrs_pkg::SLOTS; i++) begin
                    if (prrs_pkg::SLOT_W'(i) == last_slot) begin
                        slot_id_reg[i]  <= slot_id_reg[pick_reg];
                        slot_pri_reg[i] <= slot_pri_reg[pick_reg];
                        slot_rem_reg[i] <= rem_left;
                    end else if (i < prrs_pkg::SLOTS - 1 && prrs_pkg::SLOT_W'(i) >= pick_reg
                                 && prrs_pkg::SLOT_W'(i) < last_slot) begin
                        slot_id_reg[i]  <= slot_id_reg[(i + 1) % prrs_pkg::SLOTS];
                        slot_pri_reg[i] <= slot_pri_reg[(i + 1) % prrs_pkg::SLOTS];
                        slot_rem_reg[i] <= slot_rem_reg[(i + 1) % prrs_pkg::SLOTS];
                    end
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            status_reg <= prrs_pkg::STAT_OK;
            id_reg     <= '0;
            slice_reg  <= '0;
            fin_reg    <= 1'b0;
            if (op_reg == prrs_pkg::OP_ADD) begin
                if (q_full) begin
                    status_reg <= prrs_pkg::STAT_FULL;
                end else begin
                    id_reg <= next_id_reg;
                end
            end else if (q_empty) begin
                status_reg <= prrs_pkg::STAT_EMPTY;
            end else begin
                id_reg    <= slot_id_reg[pick_reg];
                slice_reg <= slice_val;
                fin_reg   <= rem_left == '0;
            end
        end
    end

    assign out_status   = status_reg;
    assign out_task_id  = id_reg;
    assign out_slice    = slice_reg;
    assign out_finished = fin_reg;

endmodule

[rtl/priority_round_robin_scheduler.sv]
// Priority round-robin scheduler. Each input transfer either adds a task
// (tuser 0) or dispatches the next slice (tuser 1), and yields exactly one
// result transfer. Items are handled one at a time: an accepted item is
// first captured, then used to update the queue and load the output
// register, and no new item is taken until that update is done. The
// priority search is a registered comparison tree over all slots that runs
// every cycle, and the update step waits only while the output register
// still holds a result that has not been taken.
module priority_round_robin_scheduler (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input channel.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: priority_req [3:0], burst [19:4], zero pad above.
    input  logic [prrs_pkg::IN_TDATA_W-1:0]        s_tdata,
    // tuser: opcode.
    input  logic                                   s_tuser,
    // Result channel.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: task_id [15:0], slice [31:16], finished [32], zero pad above.
    output logic [prrs_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // tuser: status.
    output logic [prrs_pkg::STAT_W-1:0]            m_tuser,
    // Quantum register write.
    input  logic                                   cfg_wr_en,
    input  logic [prrs_pkg::BURST_W-1:0]           cfg_wr_data
);

    prrs_pkg::cmd_t                 cmd;
    prrs_pkg::status_t              out_status;
    logic [prrs_pkg::ID_W-1:0]      out_task_id;
    logic [prrs_pkg::BURST_W-1:0]   out_slice;
    logic                           out_finished;

    prrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    prrs_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_opcode       (s_tuser),
        .in_priority_req (s_tdata[prrs_pkg::PRI_W-1:0]),
        .in_burst        (s_tdata[prrs_pkg::PRI_W +: prrs_pkg::BURST_W]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_status      (out_status),
        .out_task_id     (out_task_id),
        .out_slice       (out_slice),
        .out_finished    (out_finished)
    );

    // Result packing.
    assign m_tdata = {{prrs_pkg::OUT_PAD_W{1'b0}}, out_finished, out_slice, out_task_id};
    assign m_tuser = out_status;

endmodule

[rtl/prrs_checker.sv]
`include "priority_round_robin_scheduler_macros.svh"

module prrs_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic [prrs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [prrs_pkg::STAT_W-1:0]        m_tuser
);

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready;

    // One item at a time: no transfer in the cycle right after one.
    `PRRS_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, in_xfer, !s_tready)

    // After an input transfer is captured and executed, a result is on offer.
    `PRRS_ASSERT_NEXT(a_result_follows, aclk, aresetn, in_xfer, ##1 m_tvalid)

    // Only defined status codes leave the block.
    `PRRS_ASSERT_SAME(a_status_code, aclk, aresetn, m_tvalid, m_tuser == prrs_pkg::STAT_OK || m_tuser == prrs_pkg::STAT_FULL || m_tuser == prrs_pkg::STAT_EMPTY)

    // Error results carry no identifier, slice or finish flag.
    `PRRS_ASSERT_SAME(a_error_zero, aclk, aresetn, m_tvalid && m_tuser != prrs_pkg::STAT_OK, m_tdata == '0)

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb_priority_round_robin_scheduler.sv]
`timescale 1ns / 100ps

module tb_priority_round_robin_scheduler;

    // Longest result-side hold-off, and the longest stretch without any transfer.
    localparam int HOLD_OFF    = 400;
    localparam int STALL_LIMIT = 2000;

    // One queued job as the predictor tracks it.
    typedef struct {
        logic [prrs_pkg::ID_W-1:0]    id;
        logic [prrs_pkg::PRI_W-1:0]   prio;
        logic [prrs_pkg::BURST_W-1:0] remaining;
    } job_t;

    // One expected result transfer.
    typedef struct {
        prrs_pkg::status_t            status;
        logic [prrs_pkg::ID_W-1:0]    task_id;
        logic [prrs_pkg::BURST_W-1:0] slice;
        logic                         finished;
    } grant_t;

    // Predicts the scheduler's ready queue and checks each result in order.
    class dispatch_scoreboard;
        job_t                         ready_jobs[$];
        grant_t                       expected_grants[$];
        logic [prrs_pkg::ID_W-1:0]    next_id;
        logic [prrs_pkg::BURST_W-1:0] quantum;
        int unsigned                  errors;
        int unsigned                  n_requests;
        int unsigned                  n_checked;
        int unsigned                  n_full;
        int unsigned                  n_empty;
        int unsigned                  n_finished;

        function new();
            next_id = prrs_pkg::ID_RST;
            quantum = prrs_pkg::QUANTUM_RST;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        // Applies one accepted request to the queue and records its result.
        function void note_request(prrs_pkg::op_t op, logic [prrs_pkg::PRI_W-1:0] prio,
                                   logic [prrs_pkg::BURST_W-1:0] burst);
            grant_t g;
            job_t   j;
            int     pick;
            int     i;
            g.status   = prrs_pkg::STAT_OK;
            g.task_id  = '0;
            g.slice    = '0;
            g.finished = 1'b0;
            n_requests++;
            if (op == prrs_pkg::OP_ADD) begin
                if (ready_jobs.size() >= prrs_pkg::SLOTS) begin
                    g.status = prrs_pkg::STAT_FULL;
                    n_full++;
                end else begin
                    j.id        = next_id;
                    j.prio      = prio;
                    j.remaining = burst;
                    ready_jobs.push_back(j);
                    g.task_id = next_id;
                    next_id++;
                end
            end else if (ready_jobs.size() == 0) begin
                g.status = prrs_pkg::STAT_EMPTY;
                n_empty++;
            end else begin
                // First job in queue order among those of the highest priority.
                pick = 0;
                for (i = 1; i < ready_jobs.size(); i++) begin
                    if (ready_jobs[i].prio > ready_jobs[pick].prio) begin
                        pick = i;
                    end
                end
                j = ready_jobs[pick];
                ready_jobs.delete(pick);
                g.task_id   = j.id;
                g.slice     = (j.remaining < quantum) ? j.remaining : quantum;
                j.remaining = j.remaining - g.slice;
                if (j.remaining == 0) begin
                    g.finished = 1'b1;
                    n_finished++;
                end else begin
                    ready_jobs.push_back(j);
                end
            end
            expected_grants.push_back(g);
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_grant(logic [prrs_pkg::STAT_W-1:0] status,
                                  logic [prrs_pkg::OUT_TDATA_W-1:0] data);
            grant_t g;
            if (expected_grants.size() == 0) begin
                $error("result transfer with no request outstanding (status %0d)", status);
                errors++;
                return;
            end
            g = expected_grants.pop_front();
            n_checked++;
            if (status !== g.status) begin
                $error("status: expected %0d, actual %0d", g.status, status);
                errors++;
            end
            if (data[15:0] !== g.task_id) begin
                $error("task_id: expected %0d, actual %0d", g.task_id, data[15:0]);
                errors++;
            end
            if (data[31:16] !== g.slice) begin
                $error("slice: expected %0d, actual %0d", g.slice, data[31:16]);
                errors++;
            end
            if (data[32] !== g.finished) begin
                $error("finished: expected %0d, actual %0d", g.finished, data[32]);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [prrs_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [prrs_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [prrs_pkg::STAT_W-1:0]      m_tuser;
    logic                             cfg_wr_en;
    logic [prrs_pkg::BURST_W-1:0]     cfg_wr_data;

    dispatch_scoreboard sb = new();
    bit                 pace_on = 1'b1;
    int unsigned        results_seen;
    int unsigned        idle_cycles;

    priority_round_robin_scheduler u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // Offers one request, after a random gap when pacing is on, and waits for its transfer.
    task automatic offer_request(input prrs_pkg::op_t op,
                                 input logic [prrs_pkg::PRI_W-1:0] prio,
                                 input logic [prrs_pkg::BURST_W-1:0] burst);
        int gap;
        gap = pace_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{prrs_pkg::IN_PAD_W{1'b0}}, burst, prio};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, prio, burst);
    endtask

    // Writes the quantum once every outstanding result has been taken.
    task automatic set_quantum(input logic [prrs_pkg::BURST_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.quantum = value;
    endtask

    // Random mix of adds and dispatches; the add share steers the queue depth.
    task automatic run_mix(input int count, input int add_pct, input int prio_hi);
        prrs_pkg::op_t                op;
        logic [prrs_pkg::PRI_W-1:0]   prio;
        logic [prrs_pkg::BURST_W-1:0] burst;
        int                           roll;
        repeat (count) begin
            op   = ($urandom_range(0, 99) < add_pct) ? prrs_pkg::OP_ADD
                                                      : prrs_pkg::OP_DISPATCH;
            prio = prrs_pkg::PRI_W'($urandom_range(0, prio_hi));
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                burst = prrs_pkg::BURST_W'($urandom_range(0, 40));
            end else if (roll < 95) begin
                burst = prrs_pkg::BURST_W'($urandom_range(41, 400));
            end else begin
                burst = prrs_pkg::BURST_W'($urandom);
            end
            offer_request(op, prio, burst);
        end
    endtask

    // Result side: random ready gaps while pacing is on, two long hold-offs to back up the input.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = pace_on ? $urandom_range(0, 13) : 0;
            if (results_seen == 150 || results_seen == 900) begin
                gap = HOLD_OFF;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_grant(m_tuser, m_tdata);
            results_seen++;
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("priority_round_robin_scheduler regression: fail");
            $finish;
        end
    end

    // Main sequence: directed checks, then random phases per quantum.
    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= prrs_pkg::OP_ADD;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset quantum: empty queue, extremes, ties, full queue.
        offer_request(prrs_pkg::OP_DISPATCH, 4'hF, 16'hFFFF);
        offer_request(prrs_pkg::OP_ADD, 4'h0, 16'h0000);
        offer_request(prrs_pkg::OP_ADD, 4'hF, 16'hFFFF);
        offer_request(prrs_pkg::OP_ADD, 4'hF, 16'd25);
        offer_request(prrs_pkg::OP_ADD, 4'h7, 16'd10);
        repeat (4) begin
            offer_request(prrs_pkg::OP_DISPATCH, prrs_pkg::PRI_W'($urandom),
                          prrs_pkg::BURST_W'($urandom));
        end
        while (sb.ready_jobs.size() < prrs_pkg::SLOTS) begin
            offer_request(prrs_pkg::OP_ADD, prrs_pkg::PRI_W'($urandom),
                          prrs_pkg::BURST_W'($urandom_range(0, 30)));
        end
        offer_request(prrs_pkg::OP_ADD, 4'h3, 16'd5);
        offer_request(prrs_pkg::OP_DISPATCH, 4'h0, 16'h0000);

        // Random phases over several quantum settings, extremes included.
        run_mix(230, 50, 15);
        set_quantum(16'd1);
        run_mix(250, 70, 3);
        set_quantum(16'hFFFF);
        pace_on = 1'b0;
        run_mix(250, 35, 15);
        pace_on = 1'b1;
        set_quantum(16'd0);
        run_mix(150, 55, 15);
        set_quantum(prrs_pkg::BURST_W'($urandom_range(1, 64)));
        run_mix(250, 50, 2);
        set_quantum(prrs_pkg::BURST_W'($urandom));
        run_mix(200, 45, 15);

        // Empty the queue at the largest quantum so every dispatch finishes a job.
        set_quantum(16'hFFFF);
        pace_on = 1'b0;
        repeat (sb.ready_jobs.size()) begin
            offer_request(prrs_pkg::OP_DISPATCH, prrs_pkg::PRI_W'($urandom),
                          prrs_pkg::BURST_W'($urandom));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Checked %0d results for %0d requests: %0d adds to a full queue,",
                 sb.n_checked, sb.n_requests, sb.n_full);
        $display("%0d dispatches on an empty queue, %0d jobs finished, queue drained.",
                 sb.n_empty, sb.n_finished);
        if (sb.errors == 0) begin
            $display("priority_round_robin_scheduler regression: pass");
        end else begin
            $display("priority_round_robin_scheduler regression: fail");
        end
        $finish;
    end

endmodule
